// File: sv/lefe_pkg.sv
// lefe_pkg: shared types, constants and the color wheel function for the
// led effect frame engine; used by every module of the block but lefe_ram
package lefe_pkg;

    // sizes
    localparam int MAX_LEDS      = 64;
    localparam int KEY_POSITIONS = 128;
    localparam int LED_IDX_W     = $clog2(MAX_LEDS);
    localparam int LED_CNT_W     = 7;
    localparam int POS_W         = $clog2(KEY_POSITIONS);
    localparam int REMAP_W       = 8;
    localparam int COLOR_W       = 8;
    localparam int ACTION_W      = 3;
    localparam int ELAPSED_W     = 17;
    localparam int DELAY_W       = 16;
    localparam int RGB_W         = 3 * COLOR_W;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = RGB_W;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [ELAPSED_W-1:0] ELAPSED_TOP = {ELAPSED_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_EFFECT_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIXED_COLOR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_DELAY = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEDS = 2'd3;

    // reset values
    localparam logic [DELAY_W-1:0]   FRAME_DELAY_RST = 16'd10;
    localparam logic [LED_CNT_W-1:0] ACTIVE_LEDS_RST = 7'd64;

    // effect modes
    localparam logic MODE_RAINBOW  = 1'b0;
    localparam logic MODE_CONSTANT = 1'b1;

    // result kinds and status
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_REPLY  = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_REJ  = 1'b1;

    // color wheel segment bounds
    localparam logic [COLOR_W-1:0] WHEEL_SEG1 = 8'd85;
    localparam logic [COLOR_W-1:0] WHEEL_SEG2 = 8'd170;
    localparam logic [COLOR_W-1:0] COLOR_MAX  = 8'd255;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 3'd0,
        ACT_ENABLE  = 3'd1,
        ACT_TOGGLE  = 3'd2,
        ACT_DISABLE = 3'd3,
        ACT_LOAD    = 3'd4
    } action_t;

    // classified item handed from front to back
    typedef struct packed {
        logic                is_tick;
        action_t             action;
        logic [REMAP_W-1:0]  led;
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
    } cmd_t;

    typedef struct packed {
        logic                 effect_mode;
        logic [RGB_W-1:0]     fixed_color;
        logic [DELAY_W-1:0]   frame_delay;
        logic [LED_CNT_W-1:0] active_leds;
    } cfg_t;

    typedef struct packed {
        logic                 kind;
        logic [LED_IDX_W-1:0] pixel_index;
        logic                 write_pixel;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
        logic                 status;
        logic                 last;
    } result_t;

    // three segment color wheel, returns {red, green, blue}
    function automatic logic [RGB_W-1:0] color_wheel(input logic [COLOR_W-1:0] pos);
        logic [COLOR_W-1:0] p;
        logic [COLOR_W-1:0] t;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        p = COLOR_MAX - pos;
        if (p < WHEEL_SEG1) begin
            t = COLOR_W'(10'(p) * 10'd3);
            r = COLOR_MAX - t;
            g = '0;
            b = t;
        end else if (p < WHEEL_SEG2) begin
            t = COLOR_W'(10'(p - WHEEL_SEG1) * 10'd3);
            r = '0;
            g = t;
            b = COLOR_MAX - t;
        end else begin
            t = COLOR_W'(10'(p - WHEEL_SEG2) * 10'd3);
            r = t;
            g = COLOR_MAX - t;
            b = '0;
        end
        return {r, g, b};
    endfunction

endpackage

// File: sv/lefe_ram.sv
// lefe_ram: generic single write port ram with registered read
// no dependencies
module lefe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/lefe_front.sv
// lefe_front: accepts input items, loads the remap table, looks up the led
// for override actions and hands classified commands on; uses lefe_pkg, lefe_ram
module lefe_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [lefe_pkg::ACTION_W-1:0] action,
    input  logic [lefe_pkg::POS_W-1:0]    position,
    input  logic [lefe_pkg::REMAP_W-1:0]  remap_value,
    input  logic [lefe_pkg::COLOR_W-1:0]  red_in,
    input  logic [lefe_pkg::COLOR_W-1:0]  green_in,
    input  logic [lefe_pkg::COLOR_W-1:0]  blue_in,
    output lefe_pkg::cmd_t                cmd,
    output logic                          cmd_valid,
    input  logic                          cmd_ready
);
    import lefe_pkg::*;

    logic               stage_valid_reg;
    logic               stage_valid_next;
    logic               stage_tick_reg;
    action_t            stage_action_reg;
    logic [COLOR_W-1:0] stage_red_reg;
    logic [COLOR_W-1:0] stage_green_reg;
    logic [COLOR_W-1:0] stage_blue_reg;
    logic               accept;
    logic               is_tick;
    logic               is_override;
    logic               is_load;
    logic [REMAP_W-1:0] remap_rdata;

    // classify the incoming item
    assign accept      = push && !full;
    assign is_tick     = (action == ACT_TICK);
    assign is_load     = (action == ACT_LOAD);
    assign is_override = (action == ACT_ENABLE) || (action == ACT_TOGGLE)
                      || (action == ACT_DISABLE);

    // hold the stage while the queue cannot take it
    assign full = stage_valid_reg && !cmd_ready;

    // remap table: loads write, override actions read
    lefe_ram #(
        .WIDTH (REMAP_W),
        .DEPTH (KEY_POSITIONS)
    ) u_remap (
        .clk   (clk),
        .we    (accept && is_load),
        .waddr (position),
        .wdata (remap_value),
        .re    (accept && is_override),
        .raddr (position),
        .rdata (remap_rdata)
    );

    // stage occupancy
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = is_tick || is_override;
        end
        else if (cmd_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_tick_reg   <= is_tick;
            stage_action_reg <= action_t'(action);
            stage_red_reg    <= red_in;
            stage_green_reg  <= green_in;
            stage_blue_reg   <= blue_in;
        end
    end

    // command toward the queue
    assign cmd_valid   = stage_valid_reg;
    assign cmd.is_tick = stage_tick_reg;
    assign cmd.action  = stage_action_reg;
    assign cmd.led     = stage_tick_reg ? '0 : remap_rdata;
    assign cmd.red     = stage_red_reg;
    assign cmd.green   = stage_green_reg;
    assign cmd.blue    = stage_blue_reg;

endmodule

// File: sv/lefe_queue.sv
// lefe_queue: short command queue between front and back
// uses lefe_pkg for the command type and depth
module lefe_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  lefe_pkg::cmd_t in_cmd,
    input  logic           in_valid,
    output logic           in_ready,
    output lefe_pkg::cmd_t out_cmd,
    output logic           out_valid,
    input  logic           out_ready
);
    import lefe_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// File: sv/lefe_back.sv
// lefe_back: carries out commands: frame timing, pixel sweep, override flags
// and the result register; uses lefe_pkg
module lefe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lefe_pkg::cfg_t    cfg,
    input  lefe_pkg::cmd_t    cmd,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    output lefe_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_pop
);
    import lefe_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_FRAME
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ELAPSED_W-1:0] elapsed_next;
    logic [COLOR_W-1:0]   phase_reg;
    logic [COLOR_W-1:0]   phase_next;
    logic [COLOR_W-1:0]   base_reg;
    logic [COLOR_W-1:0]   base_next;
    logic [MAX_LEDS-1:0]  flags_reg;
    logic [MAX_LEDS-1:0]  flags_next;
    logic [LED_IDX_W-1:0] pix_reg;
    logic [LED_IDX_W-1:0] pix_next;
    logic [LED_CNT_W-1:0] count_reg;
    logic [LED_CNT_W-1:0] count_next;
    result_t              out_reg;
    result_t              out_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic                 out_free;
    logic                 take;
    logic [LED_CNT_W-1:0] leds_in_use;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic                 frame_due;
    logic                 led_ok;
    logic [LED_IDX_W-1:0] led_idx;
    logic                 flag_new;
    logic                 reply_wr;
    logic [RGB_W-1:0]     pix_rgb;
    logic                 pix_last;

    assign out_free  = !out_valid_reg || result_pop;
    assign cmd_ready = (state_reg == ST_IDLE) && out_free;
    assign take      = cmd_valid && cmd_ready;

    // frame timing
    assign leds_in_use = (cfg.active_leds > LED_CNT_W'(MAX_LEDS))
                       ? LED_CNT_W'(MAX_LEDS) : cfg.active_leds;
    assign elapsed_inc = (elapsed_reg == ELAPSED_TOP) ? elapsed_reg : elapsed_reg + 1'b1;
    assign frame_due   = elapsed_inc > ELAPSED_W'(cfg.frame_delay);

    // override flag update
    assign led_ok  = cmd.led < REMAP_W'(leds_in_use);
    assign led_idx = cmd.led[LED_IDX_W-1:0];

    always_comb
    begin
        unique case (cmd.action)
            ACT_ENABLE: flag_new = 1'b1;
            ACT_TOGGLE: flag_new = !flags_reg[led_idx];
            default:    flag_new = 1'b0;
        endcase
    end

    assign reply_wr = (cmd.action != ACT_DISABLE) && flag_new;

    // pixel color for the current sweep position
    assign pix_rgb  = (cfg.effect_mode == MODE_RAINBOW)
                    ? color_wheel(COLOR_W'(pix_reg) + base_reg) : cfg.fixed_color;
    assign pix_last = (LED_CNT_W'(pix_reg) + 1'b1) == count_reg;

    // next state
    always_comb
    begin
        state_next     = state_reg;
        elapsed_next   = elapsed_reg;
        phase_next     = phase_reg;
        base_next      = base_reg;
        flags_next     = flags_reg;
        pix_next       = pix_reg;
        count_next     = count_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_pop;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && cmd.is_tick)
                begin
                    elapsed_next = elapsed_inc;
                    if (frame_due)
                    begin
                        elapsed_next = '0;
                        base_next    = phase_reg;
                        count_next   = leds_in_use;
                        pix_next     = '0;
                        if (cfg.effect_mode == MODE_RAINBOW)
                        begin
                            phase_next = phase_reg + 1'b1;
                        end
                        if (leds_in_use != '0)
                        begin
                            state_next = ST_FRAME;
                        end
                    end
                end
                else if (take)
                begin
                    out_valid_next   = 1'b1;
                    out_next.kind    = KIND_REPLY;
                    out_next.last    = 1'b1;
                    if (led_ok)
                    begin
                        flags_next[led_idx]  = flag_new;
                        out_next.pixel_index = led_idx;
                        out_next.write_pixel = reply_wr;
                        out_next.red         = reply_wr ? cmd.red : '0;
                        out_next.green       = reply_wr ? cmd.green : '0;
                        out_next.blue        = reply_wr ? cmd.blue : '0;
                        out_next.status      = STATUS_OK;
                    end
                    else
                    begin
                        out_next.pixel_index = '0;
                        out_next.write_pixel = 1'b0;
                        out_next.red         = '0;
                        out_next.green       = '0;
                        out_next.blue        = '0;
                        out_next.status      = STATUS_REJ;
                    end
                end
            end
            ST_FRAME:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.kind        = KIND_PIXEL;
                    out_next.pixel_index = pix_reg;
                    out_next.write_pixel = !flags_reg[pix_reg];
                    out_next.red         = pix_rgb[2*COLOR_W +: COLOR_W];
                    out_next.green       = pix_rgb[COLOR_W +: COLOR_W];
                    out_next.blue        = pix_rgb[0 +: COLOR_W];
                    out_next.status      = STATUS_OK;
                    out_next.last        = pix_last;
                    pix_next             = pix_reg + 1'b1;
                    if (pix_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            elapsed_reg   <= '0;
            phase_reg     <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            elapsed_reg   <= elapsed_next;
            phase_reg     <= phase_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sweep and result payload
    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        pix_reg   <= pix_next;
        count_reg <= count_next;
        out_reg   <= out_next;
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

// File: sv/led_effect_frame_engine.sv
// led_effect_frame_engine: top level with configuration registers, front,
// command queue and back; uses lefe_pkg, lefe_front, lefe_queue, lefe_back

// Per-LED effect generator. Items enter through push/full, results leave
// through empty/pop. A tick whose elapsed count passes frame_delay produces
// one pixel result per LED in use (up to 64), one per cycle while pop keeps
// up. An override action gives one reply and a load gives none; an override
// is held in the front stage register, with the remap read done by the
// registered ram at the accepting edge. The command then moves through the
// queue and into the result register, and a due frame's pixels follow once
// the back end enters its frame state; a full queue or an unpopped result
// can stall each step. A four entry queue lets the front keep taking items
// while a frame is swept. Configuration is written through cfg_we, cfg_index
// and cfg_data.
module led_effect_frame_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [lefe_pkg::ACTION_W-1:0]    action,
    input  logic [lefe_pkg::POS_W-1:0]       position,
    input  logic [lefe_pkg::REMAP_W-1:0]     remap_value,
    input  logic [lefe_pkg::COLOR_W-1:0]     red_in,
    input  logic [lefe_pkg::COLOR_W-1:0]     green_in,
    input  logic [lefe_pkg::COLOR_W-1:0]     blue_in,
    output logic                             empty,
    input  logic                             pop,
    output logic                             kind,
    output logic [lefe_pkg::LED_IDX_W-1:0]   pixel_index,
    output logic                             write_pixel,
    output logic [lefe_pkg::COLOR_W-1:0]     red_out,
    output logic [lefe_pkg::COLOR_W-1:0]     green_out,
    output logic [lefe_pkg::COLOR_W-1:0]     blue_out,
    output logic                             status,
    output logic                             last,
    input  logic                             cfg_we,
    input  logic [lefe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lefe_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lefe_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    front_cmd;
    logic    front_valid;
    logic    front_ready;
    cmd_t    back_cmd;
    logic    back_valid;
    logic    back_ready;
    result_t result;
    logic    result_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.effect_mode <= MODE_RAINBOW;
            cfg_reg.fixed_color <= '0;
            cfg_reg.frame_delay <= FRAME_DELAY_RST;
            cfg_reg.active_leds <= ACTIVE_LEDS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EFFECT_MODE: cfg_reg.effect_mode <= cfg_data[0];
                REG_FIXED_COLOR: cfg_reg.fixed_color <= cfg_data[RGB_W-1:0];
                REG_FRAME_DELAY: cfg_reg.frame_delay <= cfg_data[DELAY_W-1:0];
                REG_ACTIVE_LEDS: cfg_reg.active_leds <= cfg_data[LED_CNT_W-1:0];
            endcase
        end
    end

    // front: accept, remap, classify
    lefe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .position    (position),
        .remap_value (remap_value),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .cmd         (front_cmd),
        .cmd_valid   (front_valid),
        .cmd_ready   (front_ready)
    );

    // command queue
    lefe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_cmd    (front_cmd),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_cmd   (back_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready)
    );

    // back: frames and overrides
    lefe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd          (back_cmd),
        .cmd_valid    (back_valid),
        .cmd_ready    (back_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_pop   (pop)
    );

    // result ports
    assign empty       = !result_valid;
    assign kind        = result.kind;
    assign pixel_index = result.pixel_index;
    assign write_pixel = result.write_pixel;
    assign red_out     = result.red;
    assign green_out   = result.green;
    assign blue_out    = result.blue;
    assign status      = result.status;
    assign last        = result.last;

`ifndef NO_ASSERTIONS
    // an override reply is always the only result of its item
    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_REPLY) |-> last)
        else $error("override reply without last");

    // frame pixels never carry a rejection
    a_pixel_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_PIXEL) |-> (status == STATUS_OK))
        else $error("frame pixel with reject status");

    // a rejected reply carries no led and no write
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_REPLY && status == STATUS_REJ)
            |-> (!write_pixel && pixel_index == '0))
        else $error("rejected reply addresses an led");

    // frame pixels stay inside the leds in use
    a_pixel_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_PIXEL)
            |-> (LED_CNT_W'(pixel_index) < cfg_reg.active_leds))
        else $error("frame pixel beyond led count");
`endif

endmodule
